// ===== rtl/core/assert_macros.svh =====
// Assertion macros included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after the antecedent, outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wpct_pkg.sv =====
// Package: constants and register indexes of the watchdog power-cycle ticker
`default_nettype none
package wpct_pkg;

  // Milliseconds per second; the millisecond counter is 10 bits wide
  localparam int unsigned MsWidth = 10;
  localparam logic [MsWidth-1:0] TICKS_PER_SECOND = MsWidth'(1000);
  localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
  localparam logic [15:0] SAT_MAX_16 = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WATCHDOG_LIMIT = 2'd0,
    REG_OFF_TIME       = 2'd1,
    REG_SAMPLE_PERIOD  = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_index_t;

  localparam logic [7:0] OFF_COUNTDOWN_RESET = 8'd2;

endpackage
`default_nettype wire

// ===== rtl/core/watchdog_power_cycle_ticker_unit.sv =====
// Top level: millisecond ticker with watchdog power cycling, LED, uptime and sample strobe
// An accepted tick request's result is held in the output register from the next cycle.
// Throughput: one tick request per cycle while results are taken; the state update is a single pass of counters.
// The output register frees itself when taken, so a new request enters in that same cycle.
// Reset (rst, synchronous): counters clear, load-off countdown loads two, power latch off,
// all configuration registers clear, and no result is pending.
`default_nettype none
`include "assert_macros.svh"
module watchdog_power_cycle_ticker_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration write channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire wpct_pkg::reg_index_t        cfg_index,
  input  wire logic [15:0]                 cfg_data,
  // tick request channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  led_load,
  input  wire logic                        sample_restart,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             load_power_on,
  output logic                             led_on,
  output logic                             sample_strobe,
  output logic [15:0]                      interval_ms,
  output logic [15:0]                      uptime_min,
  output logic [15:0]                      watchdog_count
);
  import wpct_pkg::*;

  // configuration registers
  logic [15:0] watchdog_limit;
  logic [7:0]  off_time;
  logic [15:0] sample_period;

  // tick state
  logic [MsWidth-1:0] ms_in_second, ms_in_second_next;
  logic [15:0] wd_seconds, wd_seconds_next;
  logic [7:0]  off_countdown, off_countdown_next;
  logic [5:0]  sec_in_minute, sec_in_minute_next;
  logic [15:0] minutes_up, minutes_up_next;
  logic [15:0] ms_interval, ms_interval_next;
  logic [15:0] sample_ticks, sample_ticks_next;
  logic [7:0]  led_countdown, led_countdown_next;
  logic        power_latch, power_latch_next;
  logic        led_next, strobe_next;

  // intermediate second-boundary values
  logic [MsWidth-1:0] ms_inc;
  logic [15:0] wd_inc;
  logic [7:0]  oc_loaded, oc_dec, led_loaded;
  logic [5:0]  sec_inc;
  logic [15:0] sample_base, sample_inc;

  logic in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      watchdog_limit <= '0;
      off_time       <= '0;
      sample_period  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WATCHDOG_LIMIT: watchdog_limit <= cfg_data;
        REG_OFF_TIME:       off_time       <= cfg_data[7:0];
        REG_SAMPLE_PERIOD:  sample_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  // compute the state after one tick
  always_comb begin
    // LED countdown
    led_loaded = (led_load != '0) ? led_load : led_countdown;
    led_next   = (led_loaded != '0);
    led_countdown_next = led_next ? (led_loaded - 8'd1) : led_loaded;

    // saturating interval
    ms_interval_next = (ms_interval != SAT_MAX_16) ? (ms_interval + 16'd1) : ms_interval;

    // second boundary handling
    ms_inc             = ms_in_second + MsWidth'(1);
    wd_inc             = (wd_seconds != SAT_MAX_16) ? (wd_seconds + 16'd1) : wd_seconds;
    oc_loaded          = ((watchdog_limit != '0) && (wd_inc > watchdog_limit)
                          && (off_countdown == '0)) ? off_time : off_countdown;
    oc_dec             = oc_loaded - 8'd1;
    sec_inc            = sec_in_minute + 6'd1;
    ms_in_second_next  = ms_inc;
    wd_seconds_next    = wd_seconds;
    off_countdown_next = off_countdown;
    power_latch_next   = power_latch;
    sec_in_minute_next = sec_in_minute;
    minutes_up_next    = minutes_up;
    if (ms_inc == TICKS_PER_SECOND) begin
      ms_in_second_next = '0;
      if (oc_loaded == '0) begin
        power_latch_next   = 1'b1;
        off_countdown_next = '0;
        wd_seconds_next    = wd_inc;
      end else begin
        power_latch_next   = 1'b0;
        off_countdown_next = oc_dec;
        wd_seconds_next    = (oc_dec == '0) ? '0 : wd_inc;
      end
      if (sec_inc == SECONDS_PER_MINUTE) begin
        sec_in_minute_next = '0;
        minutes_up_next    = (minutes_up != SAT_MAX_16) ? (minutes_up + 16'd1) : minutes_up;
      end else begin
        sec_in_minute_next = sec_inc;
      end
    end

    // sample strobe, 16-bit wrap
    sample_base       = sample_restart ? '0 : sample_ticks;
    sample_inc        = sample_base + 16'd1;
    strobe_next       = (sample_inc == sample_period);
    sample_ticks_next = strobe_next ? '0 : sample_inc;
  end

  // advance state on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      ms_in_second  <= '0;
      wd_seconds    <= '0;
      off_countdown <= OFF_COUNTDOWN_RESET;
      sec_in_minute <= '0;
      minutes_up    <= '0;
      ms_interval   <= '0;
      sample_ticks  <= '0;
      led_countdown <= '0;
      power_latch   <= 1'b0;
    end else if (in_accept) begin
      ms_in_second  <= ms_in_second_next;
      wd_seconds    <= wd_seconds_next;
      off_countdown <= off_countdown_next;
      sec_in_minute <= sec_in_minute_next;
      minutes_up    <= minutes_up_next;
      ms_interval   <= ms_interval_next;
      sample_ticks  <= sample_ticks_next;
      led_countdown <= led_countdown_next;
      power_latch   <= power_latch_next;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      load_power_on  <= power_latch_next;
      led_on         <= led_next;
      sample_strobe  <= strobe_next;
      interval_ms    <= ms_interval_next;
      uptime_min     <= minutes_up_next;
      watchdog_count <= wd_seconds_next;
    end
  end

  // load power only once the off countdown has run out
  `ASSERT_IMPL(a_power_needs_no_countdown, clk, rst, power_latch, off_countdown == '0,
    "load powered while off countdown runs")
  // millisecond counter stays below one second
  `ASSERT_IMPL(a_ms_in_range, clk, rst, 1'b1, ms_in_second < TICKS_PER_SECOND,
    "millisecond counter out of range")
  // a loaded LED time lights the LED on that tick
  `ASSERT_NEXT(a_led_load_lights, clk, rst, in_accept && (led_load != '0),
    out_valid && led_on, "LED not lit after load")
  // interval count never falls and is never zero after a tick
  `ASSERT_NEXT(a_interval_monotonic, clk, rst, in_accept,
    (interval_ms != '0) && (ms_interval >= $past(ms_interval)),
    "interval count fell")

endmodule
`default_nettype wire
